// File: design/assert_macros.svh
// Assertion macros used by the checker module.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CTTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`define CTTS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define CTTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ctts_pkg.sv
package ctts_pkg;

  localparam int unsigned MaxTasksDef = 16;

  typedef enum logic [1:0] {
    OpAdd      = 2'd0,
    OpDispatch = 2'd1,
    OpComplete = 2'd2,
    OpReserved = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    OutFinished = 2'd0,
    OutYielded  = 2'd1,
    OutBlocked  = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    StatOk     = 2'd0,
    StatFull   = 2'd1,
    StatSeqErr = 2'd2
  } status_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [1:0]  outcome;
    logic        unblock_on_pass;
    logic [31:0] handler_id;
  } in_data_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [4:0]  task_count;
    logic        pass_done;
    logic [31:0] run_handler;
    logic [3:0]  task_id;
    logic        dispatched;
    status_t     status;
  } out_data_t;

  typedef logic [3:0] step_t;

  localparam step_t StFetch   = 4'd0;
  localparam step_t StAdd     = 4'd1;
  localparam step_t StDisp    = 4'd2;
  localparam step_t StCpl     = 4'd3;
  localparam step_t StSeqErr  = 4'd4;
  localparam step_t StUnblk   = 4'd5;
  localparam step_t StProbe   = 4'd6;
  localparam step_t StPass    = 4'd7;
  localparam step_t StHit     = 4'd8;
  localparam step_t StCplSel  = 4'd9;
  localparam step_t StShiftRd = 4'd10;
  localparam step_t StShiftWr = 4'd11;
  localparam step_t StRemove  = 4'd12;
  localparam step_t StMark    = 4'd13;

  typedef enum logic [3:0] {
    ActNone,
    ActAdd,
    ActSeqErr,
    ActScanInit,
    ActUnblock,
    ActProbe,
    ActPass,
    ActDisp,
    ActCplInit,
    ActShiftRd,
    ActShiftWr,
    ActRemove,
    ActMark
  } act_t;

  typedef enum logic [2:0] {
    CondAlways,
    CondAccept,
    CondRunning,
    CondCplBad,
    CondScanEnd,
    CondReady,
    CondFinished,
    CondShiftDone
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t jt;
    step_t jf;
  } uword_t;

  // A taken jump from the fetch step lands on StAdd plus the opcode.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      StFetch:   w = '{ActNone,     CondAccept,    StAdd,     StFetch};
      StAdd:     w = '{ActAdd,      CondAlways,    StFetch,   StFetch};
      StDisp:    w = '{ActScanInit, CondRunning,   StSeqErr,  StUnblk};
      StCpl:     w = '{ActCplInit,  CondCplBad,    StSeqErr,  StCplSel};
      StSeqErr:  w = '{ActSeqErr,   CondAlways,    StFetch,   StFetch};
      StUnblk:   w = '{ActUnblock,  CondScanEnd,   StPass,    StProbe};
      StProbe:   w = '{ActProbe,    CondReady,     StHit,     StUnblk};
      StPass:    w = '{ActPass,     CondAlways,    StFetch,   StFetch};
      StHit:     w = '{ActDisp,     CondAlways,    StFetch,   StFetch};
      StCplSel:  w = '{ActNone,     CondFinished,  StShiftRd, StMark};
      StShiftRd: w = '{ActShiftRd,  CondShiftDone, StRemove,  StShiftWr};
      StShiftWr: w = '{ActShiftWr,  CondAlways,    StShiftRd, StShiftRd};
      StRemove:  w = '{ActRemove,   CondAlways,    StFetch,   StFetch};
      StMark:    w = '{ActMark,     CondAlways,    StFetch,   StFetch};
      default:   w = '{ActNone,     CondAlways,    StFetch,   StFetch};
    endcase
    return w;
  endfunction

endpackage

// File: design/cooperative_task_table_scheduler.sv
// Each accepted word runs through microcode steps: add, reserved opcode (sequence error), dispatch
// with an unblock and a probe step per entry scanned up to a hit or a pass, and complete, which
// shifts with a read and a write step per entry on finish, or marks on yield or block. A result step
// waits while the previous result word is still held on the output. One command is in flight;
// the next word is taken only once the result is registered and the fetch step is reached.
// Synchronous active-low reset clears the table to empty, the cursor and the running task.
module cooperative_task_table_scheduler #(
  parameter int unsigned MAX_TASKS = ctts_pkg::MaxTasksDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ctts_pkg::in_data_t  in_tdata,  // handler_id, unblock_on_pass, outcome
  input  logic [1:0]          in_tuser,  // opcode
  output logic                out_tvalid,
  input  logic                out_tready,
  output ctts_pkg::out_data_t out_tdata  // status, dispatched, task_id, run_handler,
                                         // pass_done, task_count
);

  import ctts_pkg::*;

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_TASKS);

  step_t               step_r, step_nxt;
  logic [CntW-1:0]     live_r, live_nxt;
  logic [CntW-1:0]     cursor_r, cursor_nxt;
  logic [IdxW-1:0]     run_r, run_nxt;
  logic                running_r, running_nxt;
  logic [CntW-1:0]     idx_r, idx_nxt;
  logic [MAX_TASKS-1:0] blk_r, blk_nxt;
  logic [MAX_TASKS-1:0] auto_r, auto_nxt;
  out_data_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [31:0]         hid_r;
  logic                unb_r;
  logic [1:0]          outc_r;

  logic [31:0]         hmem [MAX_TASKS];
  logic [31:0]         rdata_r;
  logic                mem_we, mem_re;
  logic [IdxW-1:0]     mem_waddr, mem_raddr;
  logic [31:0]         mem_wdata;

  uword_t              uw;
  logic                is_res, res_hold, cond_true, scan_end;
  logic [IdxW-1:0]     idx_i, live_i;
  logic [CntW-1:0]     idx_plus;
  logic                res_load, res_disp, res_pass;
  status_t             res_status;
  logic [IdxW-1:0]     res_id;
  logic [31:0]         res_handler;
  logic [IdxW+3:0]     id_ext;
  logic [CntW+4:0]     cnt_ext;

  assign in_tready  = (step_r == StFetch) && rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  assign uw       = ucode(step_r);
  assign idx_i    = idx_r[IdxW-1:0];
  assign live_i   = live_r[IdxW-1:0];
  assign idx_plus = idx_r + 1'b1;
  assign scan_end = (idx_r >= live_r);
  assign is_res   = (uw.act == ActAdd) || (uw.act == ActSeqErr) || (uw.act == ActPass) ||
                    (uw.act == ActDisp) || (uw.act == ActRemove) || (uw.act == ActMark);
  assign res_hold = is_res && out_valid_r && !out_tready;
  assign id_ext   = {4'b0, res_id};
  assign cnt_ext  = {5'b0, live_nxt};

  always_comb begin
    case (uw.cond)
      CondAlways:    cond_true = 1'b1;
      CondAccept:    cond_true = in_tvalid && in_tready;
      CondRunning:   cond_true = running_r;
      CondCplBad:    cond_true = !running_r || (CntW'(run_r) >= live_r);
      CondScanEnd:   cond_true = scan_end;
      CondReady:     cond_true = !blk_r[idx_i];
      CondFinished:  cond_true = (outc_r == OutFinished);
      CondShiftDone: cond_true = ({1'b0, idx_r} + 1'b1) >= {1'b0, live_r};
      default:       cond_true = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    live_nxt      = live_r;
    cursor_nxt    = cursor_r;
    run_nxt       = run_r;
    running_nxt   = running_r;
    idx_nxt       = idx_r;
    blk_nxt       = blk_r;
    auto_nxt      = auto_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = live_i;
    mem_wdata     = hid_r;
    mem_re        = 1'b0;
    mem_raddr     = idx_i;
    res_load      = 1'b0;
    res_status    = StatOk;
    res_disp      = 1'b0;
    res_pass      = 1'b0;
    res_id        = '0;
    res_handler   = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (!res_hold) begin
      step_nxt = cond_true ? uw.jt : uw.jf;
      if ((uw.cond == CondAccept) && cond_true) begin
        step_nxt = uw.jt + step_t'(in_tuser);
      end

      case (uw.act)
        ActAdd: begin
          res_load = 1'b1;
          if (live_r >= MaxCnt) begin
            res_status = StatFull;
          end else begin
            mem_we           = 1'b1;
            blk_nxt[live_i]  = 1'b0;
            auto_nxt[live_i] = unb_r;
            live_nxt         = live_r + 1'b1;
            res_id           = live_i;
          end
        end
        ActSeqErr: begin
          res_load   = 1'b1;
          res_status = StatSeqErr;
        end
        ActScanInit: begin
          idx_nxt = cursor_r;
        end
        ActUnblock: begin
          if (!scan_end && blk_r[idx_i] && auto_r[idx_i]) begin
            blk_nxt[idx_i] = 1'b0;
          end
        end
        ActProbe: begin
          if (!blk_r[idx_i]) begin
            cursor_nxt  = idx_r;
            run_nxt     = idx_i;
            running_nxt = 1'b1;
            mem_re      = 1'b1;
          end else begin
            idx_nxt = idx_plus;
          end
        end
        ActPass: begin
          cursor_nxt = '0;
          res_load   = 1'b1;
          res_pass   = 1'b1;
        end
        ActDisp: begin
          res_load    = 1'b1;
          res_disp    = 1'b1;
          res_id      = run_r;
          res_handler = rdata_r;
        end
        ActCplInit: begin
          idx_nxt = CntW'(run_r);
        end
        ActShiftRd: begin
          mem_re    = 1'b1;
          mem_raddr = idx_plus[IdxW-1:0];
        end
        ActShiftWr: begin
          mem_we    = 1'b1;
          mem_waddr = idx_i;
          mem_wdata = rdata_r;
          idx_nxt   = idx_plus;
        end
        ActRemove: begin
          for (int k = 0; k < int'(MAX_TASKS) - 1; k++) begin
            if ((k >= int'(run_r)) && (k + 1 < int'(live_r))) begin
              blk_nxt[k]  = blk_r[k+1];
              auto_nxt[k] = auto_r[k+1];
            end
          end
          live_nxt    = live_r - 1'b1;
          cursor_nxt  = CntW'(run_r);
          run_nxt     = '0;
          running_nxt = 1'b0;
          res_load    = 1'b1;
          res_id      = run_r;
        end
        ActMark: begin
          blk_nxt[run_r] = (outc_r == OutBlocked);
          running_nxt    = 1'b0;
          cursor_nxt     = CntW'(run_r) + 1'b1;
          res_load       = 1'b1;
          res_id         = run_r;
        end
        default: begin
        end
      endcase
    end

    if (res_load) begin
      out_valid_nxt       = 1'b1;
      out_nxt.pad         = '0;
      out_nxt.status      = res_status;
      out_nxt.dispatched  = res_disp;
      out_nxt.task_id     = id_ext[3:0];
      out_nxt.run_handler = res_handler;
      out_nxt.pass_done   = res_pass;
      out_nxt.task_count  = cnt_ext[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= StFetch;
      live_r      <= '0;
      cursor_r    <= '0;
      run_r       <= '0;
      running_r   <= 1'b0;
      blk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      live_r      <= live_nxt;
      cursor_r    <= cursor_nxt;
      run_r       <= run_nxt;
      running_r   <= running_nxt;
      blk_r       <= blk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    auto_r <= auto_nxt;
    out_r  <= out_nxt;
    if (in_tvalid && in_tready) begin
      hid_r  <= in_tdata.handler_id;
      unb_r  <= in_tdata.unblock_on_pass;
      outc_r <= in_tdata.outcome;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hmem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= hmem[mem_raddr];
    end
  end

endmodule

// File: design/ctts_chk.sv
`include "assert_macros.svh"

module ctts_chk #(
  parameter int unsigned MAX_TASKS = ctts_pkg::MaxTasksDef
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input ctts_pkg::out_data_t out_tdata  // status, dispatched, task_id, run_handler,
                                        // pass_done, task_count
);

  import ctts_pkg::*;

  localparam logic [4:0] FullCount = 5'(MAX_TASKS % 32);

  logic in_take;
  logic out_stall;
  logic full_word;
  logic full_cnt_ok;
  logic disp_word;
  logic disp_ok;

  assign in_take     = in_tvalid && in_tready;
  assign out_stall   = out_tvalid && !out_tready;
  assign full_word   = out_tvalid && (out_tdata.status == StatFull);
  assign full_cnt_ok = (out_tdata.task_count == FullCount);
  assign disp_word   = out_tvalid && out_tdata.dispatched;
  assign disp_ok     = (out_tdata.status == StatOk) && !out_tdata.pass_done &&
                       (out_tdata.task_count != 5'd0 || FullCount == 5'd0);

  `CTTS_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "Word changed")

  `CTTS_ASSERT_NEXT(a_one_in_flight, in_take, !in_tready, "Command taken while busy")

  `CTTS_ASSERT_IMPLY(a_full_count, full_word, full_cnt_ok, "Table full reported below capacity")

  `CTTS_ASSERT_IMPLY(a_dispatch_ok, disp_word, disp_ok, "Dispatch result is inconsistent")

endmodule

bind cooperative_task_table_scheduler ctts_chk #(.MAX_TASKS(MAX_TASKS)) u_ctts_chk (.*);

// File: dv/cooperative_task_table_scheduler_tb.sv
`timescale 1ns / 100ps

module cooperative_task_table_scheduler_tb;
  import ctts_pkg::*;

  localparam int TaskSlots = MaxTasksDef;
  localparam int RandomCmds = 1200;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 60;
  localparam int HoldOffAt = 150;
  localparam int HoldOffCycles = 400;
  localparam logic [1:0] OutReservedCode = 2'd3;

  typedef struct {
    opcode_t     op;
    logic [31:0] handler;
    logic        unblk;
    logic [1:0]  outcome;
  } sched_cmd_t;

  typedef struct {
    sched_cmd_t cmd;
    bit         typed;
    out_data_t  res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  in_data_t    in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  out_data_t   out_tdata;

  logic [31:0] tbl_handler [TaskSlots];
  logic        tbl_blocked [TaskSlots];
  logic        tbl_auto [TaskSlots];
  int          live;
  int          cursor;
  int          run_idx;
  bit          running;
  int          size_goal;

  out_data_t   sched_q [$];
  dir_row_t    dir_rows [$];
  int          errors;
  int          stall_cycles;
  int          words_seen;

  cooperative_task_table_scheduler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic out_data_t mk_res(status_t st, logic disp, logic [3:0] id,
                                       logic [31:0] handler, logic pass, int count);
    out_data_t r;
    r = '0;
    r.status = st;
    r.dispatched = disp;
    r.task_id = id;
    r.run_handler = handler;
    r.pass_done = pass;
    r.task_count = count[4:0];
    return r;
  endfunction

  function automatic out_data_t schedule_step(sched_cmd_t c);
    int i;
    int r;
    case (c.op)
      OpAdd: begin
        if (live >= TaskSlots) return mk_res(StatFull, 1'b0, 4'd0, 32'd0, 1'b0, live);
        tbl_handler[live] = c.handler;
        tbl_blocked[live] = 1'b0;
        tbl_auto[live] = c.unblk;
        live++;
        return mk_res(StatOk, 1'b0, 4'(live - 1), 32'd0, 1'b0, live);
      end
      OpDispatch: begin
        if (running) return mk_res(StatSeqErr, 1'b0, 4'd0, 32'd0, 1'b0, live);
        for (i = cursor; i < live; i++) begin
          if (tbl_blocked[i] && tbl_auto[i]) tbl_blocked[i] = 1'b0;
          if (!tbl_blocked[i]) begin
            cursor = i;
            run_idx = i;
            running = 1'b1;
            return mk_res(StatOk, 1'b1, 4'(i), tbl_handler[i], 1'b0, live);
          end
        end
        cursor = 0;
        return mk_res(StatOk, 1'b0, 4'd0, 32'd0, 1'b1, live);
      end
      OpComplete: begin
        if (!running || run_idx >= live)
          return mk_res(StatSeqErr, 1'b0, 4'd0, 32'd0, 1'b0, live);
        r = run_idx;
        running = 1'b0;
        if (c.outcome == OutFinished) begin
          for (i = r; i + 1 < live; i++) begin
            tbl_handler[i] = tbl_handler[i + 1];
            tbl_blocked[i] = tbl_blocked[i + 1];
            tbl_auto[i] = tbl_auto[i + 1];
          end
          live--;
          cursor = r;
          run_idx = 0;
        end else begin
          tbl_blocked[r] = (c.outcome == OutBlocked);
          cursor = r + 1;
        end
        return mk_res(StatOk, 1'b0, 4'(r), 32'd0, 1'b0, live);
      end
      default: return mk_res(StatSeqErr, 1'b0, 4'd0, 32'd0, 1'b0, live);
    endcase
  endfunction

  // Entries blocked without auto-unblock can never leave the table.
  function automatic int stuck_entries();
    int n;
    n = 0;
    for (int i = 0; i < live; i++) if (tbl_blocked[i] && !tbl_auto[i]) n++;
    return n;
  endfunction

  function automatic sched_cmd_t pick_command();
    sched_cmd_t c;
    int roll;
    c.handler = $urandom;
    c.unblk = 1'($urandom_range(0, 1));
    c.outcome = 2'($urandom_range(0, 3));
    c.op = OpDispatch;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      c.op = opcode_t'($urandom_range(0, 3));
    end else if (running) begin
      if (live <= size_goal && roll < 30) begin
        c.op = OpAdd;
      end else begin
        c.op = OpComplete;
        roll = $urandom_range(0, 99);
        if (live > size_goal)
          c.outcome = roll < 70 ? OutFinished : (roll < 85 ? OutYielded : OutBlocked);
        else if (roll < 20) c.outcome = OutFinished;
        else if (roll < 45) c.outcome = OutYielded;
        else if (roll < 55) c.outcome = OutReservedCode;
        else c.outcome = OutBlocked;
      end
    end else if (live <= size_goal && roll < 50) begin
      c.op = OpAdd;
    end
    if (c.op == OpComplete && running && c.outcome == OutBlocked && !tbl_auto[run_idx] &&
        stuck_entries() >= 3)
      c.outcome = OutYielded;
    return c;
  endfunction

  function automatic void add_row(opcode_t op, logic [31:0] handler, logic unblk,
                                  logic [1:0] outcome, bit typed, out_data_t res);
    dir_row_t row;
    row.cmd.op = op;
    row.cmd.handler = handler;
    row.cmd.unblk = unblk;
    row.cmd.outcome = outcome;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  task automatic send_cmd(sched_cmd_t c, bit typed, out_data_t typed_res, bit gaps);
    out_data_t pred;
    int gap;
    pred = schedule_step(c);
    sched_q.push_back(typed ? typed_res : pred);
    gap = gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = '0;
    in_tdata.handler_id = c.handler;
    in_tdata.unblock_on_pass = c.unblk;
    in_tdata.outcome = c.outcome;
    in_tuser = c.op;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= StallLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, StallLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    out_data_t got;
    out_data_t want;
    int w;
    bit gaps;
    out_tready = 1'b0;
    words_seen = 0;
    gaps = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      if (words_seen % 50 == 0) gaps = ($urandom_range(0, 3) != 0);
      w = gaps ? $urandom_range(0, 18) : 0;
      if (words_seen == HoldOffAt) w = HoldOffCycles;
      if (w > 0) begin
        out_tready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata;
      words_seen++;
      if (sched_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected: status %0d disp %0d id %0d",
                 $time, got.status, got.dispatched, got.task_id);
      end else begin
        want = sched_q.pop_front();
        if (got.status !== want.status || got.dispatched !== want.dispatched ||
            got.task_id !== want.task_id || got.run_handler !== want.run_handler ||
            got.pass_done !== want.pass_done || got.task_count !== want.task_count) begin
          errors++;
          $display("%0t: expected st %0d disp %0d id %0d hdl %h pass %0d cnt %0d",
                   $time, want.status, want.dispatched, want.task_id, want.run_handler,
                   want.pass_done, want.task_count);
          $display("%0t: actual   st %0d disp %0d id %0d hdl %h pass %0d cnt %0d",
                   $time, got.status, got.dispatched, got.task_id, got.run_handler,
                   got.pass_done, got.task_count);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    bit gaps;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OpAdd;
    errors = 0;
    live = 0;
    cursor = 0;
    run_idx = 0;
    running = 1'b0;
    size_goal = 4;
    for (int i = 0; i < TaskSlots; i++) begin
      tbl_handler[i] = '0;
      tbl_blocked[i] = 1'b0;
      tbl_auto[i] = 1'b0;
    end

    add_row(OpDispatch, 32'd0, 1'b0, OutFinished, 1'b1,
            mk_res(StatOk, 1'b0, 4'd0, 32'd0, 1'b1, 0));
    add_row(OpComplete, 32'd0, 1'b0, OutYielded, 1'b1,
            mk_res(StatSeqErr, 1'b0, 4'd0, 32'd0, 1'b0, 0));
    add_row(OpReserved, 32'hFFFF_FFFF, 1'b1, OutReservedCode, 1'b1,
            mk_res(StatSeqErr, 1'b0, 4'd0, 32'd0, 1'b0, 0));
    add_row(OpAdd, 32'd0, 1'b0, OutFinished, 1'b1,
            mk_res(StatOk, 1'b0, 4'd0, 32'd0, 1'b0, 1));
    add_row(OpAdd, 32'hFFFF_FFFF, 1'b1, OutReservedCode, 1'b1,
            mk_res(StatOk, 1'b0, 4'd1, 32'd0, 1'b0, 2));
    for (int i = 2; i < TaskSlots; i++)
      add_row(OpAdd, $urandom, 1'($urandom_range(0, 1)), OutFinished, 1'b0, '0);
    add_row(OpAdd, $urandom, 1'b1, OutFinished, 1'b1,
            mk_res(StatFull, 1'b0, 4'd0, 32'd0, 1'b0, TaskSlots));
    add_row(OpDispatch, 32'd0, 1'b0, OutFinished, 1'b0, '0);
    add_row(OpDispatch, 32'd0, 1'b0, OutFinished, 1'b1,
            mk_res(StatSeqErr, 1'b0, 4'd0, 32'd0, 1'b0, TaskSlots));
    add_row(OpComplete, 32'd0, 1'b0, OutFinished, 1'b0, '0);
    add_row(OpDispatch, 32'd0, 1'b0, OutFinished, 1'b0, '0);
    add_row(OpAdd, 32'hA5A5_5A5A, 1'b1, OutFinished, 1'b0, '0);
    add_row(OpComplete, 32'd0, 1'b0, OutReservedCode, 1'b0, '0);
    add_row(OpDispatch, 32'd0, 1'b0, OutFinished, 1'b0, '0);
    add_row(OpComplete, 32'd0, 1'b0, OutBlocked, 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[k])
      send_cmd(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].res, 1'b1);

    gaps = 1'b1;
    for (int n = 0; n < RandomCmds; n++) begin
      if (n % 100 == 0) size_goal = ($urandom_range(0, 3) == 0) ? TaskSlots : $urandom_range(1, 5);
      if (n % 64 == 0) gaps = ($urandom_range(0, 3) != 0);
      send_cmd(pick_command(), 1'b0, '0, gaps);
    end
    in_tvalid = 1'b0;

    while (sched_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
